// ----- rtl/dst_pkg.sv -----
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants for the unique-value set table.
// ----------------------------------------------------------------------------
package dst_pkg;

	// Table geometry.
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the item ports.
	localparam int COMMAND_W = 2;
	localparam int VALUE_W   = 32;
	localparam int INDEX_W   = 4;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 5;

	// Command codes. The unused code decodes as a read.
	localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [COMMAND_W-1:0] CMD_READ   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		RES_INSERTED  = 3'd0,
		RES_DUPLICATE = 3'd1,
		RES_FULL      = 3'd2,
		RES_REMOVED   = 3'd3,
		RES_NOTFOUND  = 3'd4,
		RES_READOK    = 3'd5,
		RES_BEYOND    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FETCH,
		ST_COMPARE,
		ST_SHIFT_CHK,
		ST_SHIFT_WR,
		ST_RFETCH,
		ST_RDATA,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RA_PTR,
		RA_NEXT,
		RA_INDEX
	} raddr_sel_t;

	// Conditions seen by the sequencer. in_search decodes the offered item,
	// the others the item being worked on.
	typedef struct packed {
		logic in_valid;
		logic in_search;
		logic is_remove;
		logic at_end;
		logic match;
		logic full;
		logic last_shift;
		logic index_ok;
		logic out_free;
	} seq_flags_t;

	// Controls driven by the sequencer into the datapath.
	typedef struct packed {
		logic       accept;
		logic       busy;
		logic       ptr_clr;
		logic       ptr_inc;
		raddr_sel_t raddr_sel;
		logic       mem_we;
		logic       wr_at_count;
		logic       count_inc;
		logic       count_dec;
		logic       status_we;
		status_t    status_code;
		logic       rdval_we;
		logic       load_out;
	} seq_ctl_t;

endpackage

// ----- rtl/dst_seq.sv -----
// ----------------------------------------------------------------------------
// dst_seq
// Sequencer for the set table: walks the entries one at a time through the
// shared compare unit and the one read and one write port of the memory.
// ----------------------------------------------------------------------------
module dst_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  dst_pkg::seq_flags_t flags,
	output dst_pkg::seq_ctl_t   ctl
);

	dst_pkg::state_t state_q;
	dst_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dst_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dst_pkg::ST_IDLE: begin
				if (flags.in_valid) begin
					if (flags.in_search) begin
						state_nxt = dst_pkg::ST_CHECK;
					end else begin
						state_nxt = dst_pkg::ST_RFETCH;
					end
				end
			end
			dst_pkg::ST_CHECK: begin
				if (flags.at_end) begin
					state_nxt = dst_pkg::ST_FINISH;
				end else begin
					state_nxt = dst_pkg::ST_FETCH;
				end
			end
			dst_pkg::ST_FETCH: begin
				state_nxt = dst_pkg::ST_COMPARE;
			end
			dst_pkg::ST_COMPARE: begin
				if (flags.match) begin
					if (flags.is_remove) begin
						state_nxt = dst_pkg::ST_SHIFT_CHK;
					end else begin
						state_nxt = dst_pkg::ST_FINISH;
					end
				end else begin
					state_nxt = dst_pkg::ST_CHECK;
				end
			end
			dst_pkg::ST_SHIFT_CHK: begin
				if (flags.last_shift) begin
					state_nxt = dst_pkg::ST_FINISH;
				end else begin
					state_nxt = dst_pkg::ST_SHIFT_WR;
				end
			end
			dst_pkg::ST_SHIFT_WR: begin
				state_nxt = dst_pkg::ST_SHIFT_CHK;
			end
			dst_pkg::ST_RFETCH: begin
				if (flags.index_ok) begin
					state_nxt = dst_pkg::ST_RDATA;
				end else begin
					state_nxt = dst_pkg::ST_FINISH;
				end
			end
			dst_pkg::ST_RDATA: begin
				state_nxt = dst_pkg::ST_FINISH;
			end
			dst_pkg::ST_FINISH: begin
				if (flags.out_free) begin
					state_nxt = dst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl             = '0;
		ctl.busy        = (state_q != dst_pkg::ST_IDLE);
		ctl.raddr_sel   = dst_pkg::RA_PTR;
		ctl.status_code = dst_pkg::RES_INSERTED;
		case (state_q)
			dst_pkg::ST_IDLE: begin
				ctl.accept  = flags.in_valid;
				ctl.ptr_clr = flags.in_valid;
			end
			dst_pkg::ST_CHECK: begin
				if (flags.at_end) begin
					ctl.status_we = 1'b1;
					if (flags.is_remove) begin
						ctl.status_code = dst_pkg::RES_NOTFOUND;
					end else if (flags.full) begin
						ctl.status_code = dst_pkg::RES_FULL;
					end else begin
						ctl.status_code = dst_pkg::RES_INSERTED;
						ctl.mem_we      = 1'b1;
						ctl.wr_at_count = 1'b1;
						ctl.count_inc   = 1'b1;
					end
				end
			end
			dst_pkg::ST_FETCH: begin
				ctl.raddr_sel = dst_pkg::RA_PTR;
			end
			dst_pkg::ST_COMPARE: begin
				if (flags.match) begin
					if (!flags.is_remove) begin
						ctl.status_we   = 1'b1;
						ctl.status_code = dst_pkg::RES_DUPLICATE;
					end
				end else begin
					ctl.ptr_inc = 1'b1;
				end
			end
			dst_pkg::ST_SHIFT_CHK: begin
				ctl.raddr_sel = dst_pkg::RA_NEXT;
				if (flags.last_shift) begin
					ctl.count_dec   = 1'b1;
					ctl.status_we   = 1'b1;
					ctl.status_code = dst_pkg::RES_REMOVED;
				end
			end
			dst_pkg::ST_SHIFT_WR: begin
				ctl.mem_we  = 1'b1;
				ctl.ptr_inc = 1'b1;
			end
			dst_pkg::ST_RFETCH: begin
				ctl.raddr_sel = dst_pkg::RA_INDEX;
				if (!flags.index_ok) begin
					ctl.status_we   = 1'b1;
					ctl.status_code = dst_pkg::RES_BEYOND;
				end
			end
			dst_pkg::ST_RDATA: begin
				ctl.rdval_we    = 1'b1;
				ctl.status_we   = 1'b1;
				ctl.status_code = dst_pkg::RES_READOK;
			end
			dst_pkg::ST_FINISH: begin
				ctl.load_out = flags.out_free;
			end
			default: begin
				ctl.busy = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/dedup_set_table.sv -----
// ----------------------------------------------------------------------------
// dedup_set_table
// Ordered table of unique signed values with insert, remove and indexed read.
// ----------------------------------------------------------------------------
//
//  channel | signals                           | direction | accepted when
//  --------+-----------------------------------+-----------+--------------------
//  in      | in_valid, in_stall, command,      | in        | in_valid & !in_stall
//          | value, index                      |           |
//  out     | out_valid, out_stall, status,     | out       | out_valid & !out_stall
//          | read_value, count                 |           |
//
//  The search examines one entry at a time through the CHECK, FETCH and
//  COMPARE states, so an insert or remove visits every entry up to the
//  first match; a remove that finds its value then moves each later entry
//  down through SHIFT_CHK and SHIFT_WR. A read passes RFETCH and RDATA, or
//  skips RDATA for an index at or past the count. Each step goes through the
//  one read and one write port of the entry memory and the single comparator.
//  in_stall is high from the item's acceptance until its result is loaded
//  into the output register; a held result lets the next item in, but that
//  item's result then waits in the last state until the output frees up.
//  Reset clears the count and the control state; the entry memory is not
//  cleared and needs no pass after reset.
// ----------------------------------------------------------------------------
module dedup_set_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	input  logic [3:0]         index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] read_value,
	output logic [4:0]         count
);

	dst_pkg::seq_flags_t flags;
	dst_pkg::seq_ctl_t   ctl;

	logic [dst_pkg::COMMAND_W-1:0] cmd_q;
	logic [dst_pkg::VALUE_W-1:0]   value_q;
	logic [dst_pkg::INDEX_W-1:0]   idx_q;
	logic [dst_pkg::CNT_W-1:0]     ptr_q;
	logic [dst_pkg::CNT_W-1:0]     ptr_next;
	logic [dst_pkg::CNT_W-1:0]     count_q;
	logic [dst_pkg::VALUE_W-1:0]   mem [dst_pkg::DEPTH];
	logic [dst_pkg::VALUE_W-1:0]   rdata_q;
	logic [dst_pkg::IDX_W-1:0]     raddr;
	logic [dst_pkg::IDX_W-1:0]     waddr;
	logic [dst_pkg::VALUE_W-1:0]   rdval_q;
	dst_pkg::status_t              status_q;
	logic                          out_valid_q;
	dst_pkg::status_t              out_status_q;
	logic [dst_pkg::VALUE_W-1:0]   out_rdval_q;
	logic [dst_pkg::CNT_W-1:0]     out_count_q;

	assign ptr_next = ptr_q + dst_pkg::CNT_W'(1);

	// The branch taken on acceptance depends on the offered command, since
	// the item registers load only at that edge.
	assign flags.in_valid   = in_valid;
	assign flags.in_search  = (command == dst_pkg::CMD_INSERT) ||
		(command == dst_pkg::CMD_REMOVE);
	assign flags.is_remove  = (cmd_q == dst_pkg::CMD_REMOVE);
	assign flags.at_end     = (ptr_q == count_q);
	assign flags.match      = (rdata_q == value_q);
	assign flags.full       = (count_q == dst_pkg::CNT_W'(dst_pkg::DEPTH));
	assign flags.last_shift = (ptr_next == count_q);
	assign flags.index_ok   = ((dst_pkg::INDEX_W + dst_pkg::CNT_W)'(idx_q) <
		(dst_pkg::INDEX_W + dst_pkg::CNT_W)'(count_q));
	assign flags.out_free   = !out_valid_q || !out_stall;

	dst_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	// Item registers; the result value is cleared so that anything but a
	// good read reports zero.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= command;
			value_q <= value;
			idx_q   <= index;
		end
		if (ctl.accept) begin
			rdval_q <= '0;
		end else if (ctl.rdval_we) begin
			rdval_q <= rdata_q;
		end
		if (ctl.status_we) begin
			status_q <= ctl.status_code;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ptr_clr) begin
			ptr_q <= '0;
		end else if (ctl.ptr_inc) begin
			ptr_q <= ptr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.count_inc) begin
			count_q <= count_q + dst_pkg::CNT_W'(1);
		end else if (ctl.count_dec) begin
			count_q <= count_q - dst_pkg::CNT_W'(1);
		end
	end

	always_comb begin
		case (ctl.raddr_sel)
			dst_pkg::RA_PTR:   raddr = ptr_q[dst_pkg::IDX_W-1:0];
			dst_pkg::RA_NEXT:  raddr = ptr_next[dst_pkg::IDX_W-1:0];
			dst_pkg::RA_INDEX: raddr = dst_pkg::IDX_W'(idx_q);
			default:           raddr = ptr_q[dst_pkg::IDX_W-1:0];
		endcase
	end

	// An insert appends at the count; a shift moves the entry read last
	// cycle down to the pointer.
	assign waddr = ctl.wr_at_count ? count_q[dst_pkg::IDX_W-1:0]
		: ptr_q[dst_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			mem[waddr] <= ctl.wr_at_count ? value_q : rdata_q;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q <= status_q;
			out_rdval_q  <= rdval_q;
			out_count_q  <= count_q;
		end
	end

	assign in_stall   = ctl.busy;
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_rdval_q;
	assign count      = dst_pkg::COUNT_W'(out_count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dst_pkg::CNT_W'(dst_pkg::DEPTH))
		else $error("entry count above table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not make the block busy");

	a_count_moves_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(in_stall))
		else $error("entry count changed while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || !out_stall))
		else $error("held result overwritten");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mem_we |-> (in_stall && !ctl.count_dec))
		else $error("memory written outside a command");

endmodule
